// ===== hw/rtl/b2da_pkg.sv =====
package b2da_pkg;

   localparam int unsigned DIGIT_BITS = 4;
   localparam int unsigned CHAR_BITS  = 6;
   localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;
   localparam logic [DIGIT_BITS-1:0] DABBLE_LIMIT = 4'd5;
   localparam logic [DIGIT_BITS-1:0] DABBLE_ADJUST = 4'd3;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   // one digit handed from the sequencer to the output register
   typedef struct packed {
      logic                  valid;
      logic [DIGIT_BITS-1:0] nibble;
      logic                  last;
   } digit_type;

endpackage

// ===== hw/rtl/b2da_dabble_step.sv =====
module b2da_dabble_step #(
   parameter int unsigned NDIG = 10
) (
   input  logic [b2da_pkg::DIGIT_BITS*NDIG-1:0] bcd,
   input  logic                                 bit_in,
   output logic [b2da_pkg::DIGIT_BITS*NDIG-1:0] bcd_next
);

   localparam int unsigned DB = b2da_pkg::DIGIT_BITS;

   logic [DB*NDIG-1:0] adjusted;

   // add 3 to every digit of 5 or more, then shift in the next binary bit
   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         if (bcd[DB*i +: DB] >= b2da_pkg::DABBLE_LIMIT) begin
            adjusted[DB*i +: DB] = bcd[DB*i +: DB] + b2da_pkg::DABBLE_ADJUST;
         end else begin
            adjusted[DB*i +: DB] = bcd[DB*i +: DB];
         end
      end
   end

   assign bcd_next = {adjusted[DB*NDIG-2:0], bit_in};

endmodule

// ===== hw/rtl/b2da_rsp_reg.sv =====
module b2da_rsp_reg (
   input  logic                               clock,
   input  logic                               reset,
   input  b2da_pkg::digit_type                digit,
   output logic                               free,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [b2da_pkg::CHAR_BITS-1:0]     rsp_digit_char,
   output logic                               rsp_last
);

   logic                           valid_ff;
   logic                           valid_in;
   logic [b2da_pkg::CHAR_BITS-1:0] char_ff;
   logic                           last_ff;

   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (digit.valid) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (digit.valid) begin
         char_ff <= b2da_pkg::ASCII_ZERO
                    + {{(b2da_pkg::CHAR_BITS-b2da_pkg::DIGIT_BITS){1'b0}}, digit.nibble};
         last_ff <= digit.last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last       = last_ff;

endmodule

// ===== hw/rtl/binary_to_decimal_ascii.sv =====
// Binary to decimal ASCII converter.
// req_ channel: one unsigned req_value per transaction. req_stall stays high
// while a number is being converted or its digits are being sent.
// rsp_ channel: one transaction per decimal digit, most significant first,
// no leading zeros; rsp_last marks the least significant digit. Zero gives
// a single '0' with rsp_last set.
// Timing: the double-dabble step unit converts the VALUE_BITS-bit value one
// bit per cycle, then the sequencer walks NDIG digit positions one per cycle,
// dropping leading zeros and handing each kept digit to the output register;
// a kept digit waits while the output register is full and stalled.
// A new number is taken only after the last digit of the previous one has
// been handed to the output register.
// A stall on rsp_ holds the output register and freezes digit emission; the
// final digit may wait in the output register while the next number is
// already accepted and converted.
// Reset (synchronous) returns to idle and drops rsp_valid; nothing else.
module binary_to_decimal_ascii #(
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [VALUE_BITS-1:0]              req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [b2da_pkg::CHAR_BITS-1:0]     rsp_digit_char,
   output logic                               rsp_last
);

   localparam int unsigned DB   = b2da_pkg::DIGIT_BITS;
   localparam int unsigned NDIG = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int unsigned CW   = $clog2(VALUE_BITS);
   localparam int unsigned RW   = $clog2(NDIG + 1);

   b2da_pkg::state_type state_ff, state_in;
   logic [VALUE_BITS-1:0] shift_ff, shift_in;
   logic [DB*NDIG-1:0]    bcd_ff, bcd_in, bcd_step;
   logic [CW-1:0]         count_ff, count_in;
   logic [RW-1:0]         remain_ff, remain_in;
   logic                  started_ff, started_in;
   logic [DB-1:0]         top_digit;
   logic                  out_free;
   b2da_pkg::digit_type   digit;

   b2da_dabble_step #(.NDIG(NDIG)) u_step (
      .bcd      (bcd_ff),
      .bit_in   (shift_ff[VALUE_BITS-1]),
      .bcd_next (bcd_step)
   );

   b2da_rsp_reg u_rsp (
      .clock          (clock),
      .reset          (reset),
      .digit          (digit),
      .free           (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   assign req_stall = (state_ff != b2da_pkg::ST_IDLE);
   assign top_digit = bcd_ff[DB*NDIG-1 -: DB];

   always_comb begin
      state_in     = state_ff;
      shift_in     = shift_ff;
      bcd_in       = bcd_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      started_in   = started_ff;
      digit.valid  = 1'b0;
      digit.nibble = top_digit;
      digit.last   = (remain_ff == RW'(1));
      unique case (state_ff)
         b2da_pkg::ST_IDLE: begin
            if (req_valid) begin
               shift_in = req_value;
               bcd_in   = '0;
               count_in = '0;
               state_in = b2da_pkg::ST_CONV;
            end
         end
         b2da_pkg::ST_CONV: begin
            shift_in = shift_ff << 1;
            bcd_in   = bcd_step;
            count_in = count_ff + CW'(1);
            if (count_ff == CW'(VALUE_BITS - 1)) begin
               remain_in  = RW'(NDIG);
               started_in = 1'b0;
               state_in   = b2da_pkg::ST_EMIT;
            end
         end
         b2da_pkg::ST_EMIT: begin
            // leading zero: drop it, but always keep the units digit
            if (!started_ff && top_digit == '0 && remain_ff != RW'(1)) begin
               bcd_in    = {bcd_ff[DB*NDIG-DB-1:0], {DB{1'b0}}};
               remain_in = remain_ff - RW'(1);
            end else if (out_free) begin
               digit.valid = 1'b1;
               bcd_in      = {bcd_ff[DB*NDIG-DB-1:0], {DB{1'b0}}};
               remain_in   = remain_ff - RW'(1);
               started_in  = 1'b1;
               if (remain_ff == RW'(1)) begin
                  state_in = b2da_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = b2da_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= b2da_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff   <= shift_in;
      bcd_ff     <= bcd_in;
      count_ff   <= count_in;
      remain_ff  <= remain_in;
      started_ff <= started_in;
   end

   a_accept_starts_conv: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == b2da_pkg::ST_CONV))
      else $error("accepted transaction did not start conversion");

   a_no_digit_outside_emit: assert property (@(posedge clock) disable iff (reset)
      digit.valid |-> (state_ff == b2da_pkg::ST_EMIT))
      else $error("digit loaded outside emit state");

   a_last_ends_number: assert property (@(posedge clock) disable iff (reset)
      (digit.valid && digit.last) |=> (state_ff == b2da_pkg::ST_IDLE))
      else $error("last digit did not return to idle");

   a_emit_has_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == b2da_pkg::ST_EMIT) |-> (remain_ff != '0))
      else $error("emit state with no digits left");

endmodule

// ===== tb/sv/b2da_digit_checker.sv =====
`timescale 1ns / 100ps

module b2da_digit_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [31:0]                   req_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [b2da_pkg::CHAR_BITS-1:0] rsp_digit_char,
   input  logic                          rsp_last,
   output int                            fail_count,
   output int                            digits_pending,
   output int                            numbers_seen,
   output int                            digits_checked
);

   localparam logic [31:0] DECIMAL_BASE = 32'd10;

   typedef struct {
      logic [b2da_pkg::CHAR_BITS-1:0] digit_char;
      logic                           last;
   } ascii_digit_type;

   ascii_digit_type expected_digits[$];
   ascii_digit_type oldest_digit;

   // least significant digit is worked out first, queued most significant first
   function automatic void queue_decimal_digits(input logic [31:0] value);
      logic [3:0] reversed[10];
      logic [31:0] rest;
      int count;
      rest = value;
      count = 0;
      do begin
         reversed[count] = 4'(rest % DECIMAL_BASE);
         rest = rest / DECIMAL_BASE;
         count++;
      end while (rest != 0);
      for (int k = count - 1; k >= 0; k--) begin
         ascii_digit_type d;
         d.digit_char = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_BITS'(reversed[k]);
         d.last = (k == 0);
         expected_digits.push_back(d);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            queue_decimal_digits(req_value);
            numbers_seen++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_digits.size() == 0) begin
               $error("unexpected digit transaction: digit_char %0d last %0b",
                      rsp_digit_char, rsp_last);
               fail_count++;
            end else begin
               oldest_digit = expected_digits.pop_front();
               digits_checked++;
               if (rsp_digit_char !== oldest_digit.digit_char) begin
                  $error("digit_char expected %0d actual %0d",
                         oldest_digit.digit_char, rsp_digit_char);
                  fail_count++;
               end
               if (rsp_last !== oldest_digit.last) begin
                  $error("last expected %0b actual %0b", oldest_digit.last, rsp_last);
                  fail_count++;
               end
            end
         end
         digits_pending = expected_digits.size();
      end
   end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

   localparam int RANDOM_NUMBERS = 300;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 64;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [31:0]                    req_value;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [b2da_pkg::CHAR_BITS-1:0] rsp_digit_char;
   logic                           rsp_last;

   int fail_count;
   int digits_pending;
   int numbers_seen;
   int digits_checked;
   int cycle_count;
   bit no_idle;

   binary_to_decimal_ascii #(.VALUE_BITS(32)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   b2da_digit_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last),
      .fail_count     (fail_count),
      .digits_pending (digits_pending),
      .numbers_seen   (numbers_seen),
      .digits_checked (digits_checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d digits still expected",
                     cycle_count, digits_pending);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // entered at a falling edge; valid stays high across back-to-back numbers
   task automatic send_number(input logic [31:0] value);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   // receiver: stall for a drawn number of cycles before each digit
   initial begin
      int hold;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 11);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   initial begin
      logic [31:0] directed[$];
      longint unsigned low_bound;
      longint unsigned high_bound;
      int ndigits;
      reset = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      no_idle = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero, digit-count boundaries, values past one billion, bit patterns
      directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd909,
                   32'd999999999, 32'd1000000000, 32'd1000000001,
                   32'd4294967295, 32'd4294967294, 32'd4000000000,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                   32'd1234567890, 32'd9876543, 32'd100000, 32'd65535,
                   32'd0, 32'd5};
      foreach (directed[i]) send_number(directed[i]);

      for (int i = 0; i < RANDOM_NUMBERS; i++) begin
         no_idle = ((i / 25) % 4) == 3;
         case ($urandom_range(0, 3))
            0: send_number($urandom);
            3: send_number($urandom_range(0, 999));
            default: begin
               // value with a chosen number of digits
               ndigits = $urandom_range(1, 10);
               low_bound = 1;
               for (int d = 1; d < ndigits; d++) low_bound = low_bound * 10;
               high_bound = low_bound * 10 - 1;
               if (high_bound > 64'hFFFF_FFFF) high_bound = 64'hFFFF_FFFF;
               send_number(32'(low_bound + ({$urandom, $urandom} %
                                            (high_bound - low_bound + 1))));
            end
         endcase
      end
      req_valid <= 1'b0;
      no_idle = 1'b0;

      while (digits_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("converted %0d numbers into %0d checked digits", numbers_seen, digits_checked);
      $display("covered zero, digit-count edges, full 32-bit range, gaps of 0..11 cycles");
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
